// ----- rtl/tsc_pkg.sv -----
// Shared constants, codes and types of the tiny 16-bit processor step block.
package tsc_pkg;

  localparam int unsigned MEM_WORDS = 64;
  localparam int unsigned AW        = $clog2(MEM_WORDS);
  localparam int unsigned RF_DEPTH  = 16;
  localparam int unsigned RF_AW     = 4;

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_EXEC  = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  localparam logic [1:0] ST_EXEC = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_MEM  = 2'd2;

  localparam logic [3:0] OP_HALT  = 4'h0;
  localparam logic [3:0] OP_ADD   = 4'h1;
  localparam logic [3:0] OP_SUB   = 4'h2;
  localparam logic [3:0] OP_LOAD  = 4'h3;
  localparam logic [3:0] OP_STORE = 4'h4;
  localparam logic [3:0] OP_LDL   = 4'h5;
  localparam logic [3:0] OP_LDH   = 4'h6;
  localparam logic [3:0] OP_MOVE  = 4'h7;
  localparam logic [3:0] OP_JUMP  = 4'h8;
  localparam logic [3:0] OP_BR    = 4'h9;
  localparam logic [3:0] OP_BZ    = 4'hA;
  localparam logic [3:0] OP_OUT   = 4'hE;

  localparam logic [RF_AW-1:0] REG_ZERO = 4'd0;
  localparam logic [RF_AW-1:0] REG_PC   = 4'd15;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_valid;
    logic [15:0] out_value;
    logic [15:0] read_data;
    logic [15:0] program_counter;
  } tsc_res_t;

  // Memory address from the 6-bit request address, modulo the memory size.
  function automatic logic [AW-1:0] wrap_addr6(input logic [5:0] a);
    logic [AW+5:0] t;
    t = {{AW{1'b0}}, a};
    return t[AW-1:0];
  endfunction

endpackage

// ----- rtl/tsc_intf.sv -----
// Request and response channel interfaces of the processor step block.
interface tsc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  mem_address;
  logic [15:0] mem_data;

  modport source (output valid, output func, output mem_address, output mem_data,
                  input ready);
  modport sink   (input valid, input func, input mem_address, input mem_data,
                  output ready);
endinterface

interface tsc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        out_valid;
  logic [15:0] out_value;
  logic [15:0] read_data;
  logic [15:0] program_counter;

  modport source (output valid, output status, output out_valid, output out_value,
                  output read_data, output program_counter, input ready);
  modport sink   (input valid, input status, input out_valid, input out_value,
                  input read_data, input program_counter, output ready);
endinterface

// ----- rtl/tsc_ram.sv -----
// Generic RAM: one write port, two read ports with registered, enabled read data.
module tsc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ----- rtl/tiny_sixteen_bit_cpu_step.sv -----
// Memory items and execute-while-halted go from the request through the memory state to a
// registered result; instructions pass accept/fetch, decode/register read, operand read, execute.
// Requests are served one at a time, bounded by the serial fetch and register-file read
// sequence; one result may wait in the output, and a further result holds until it is taken.
// Reset: a clearing pass over all MEM_WORDS addresses zeroes program memory and registers,
// with ready low; the program counter and halt flag reset at once.
module tiny_sixteen_bit_cpu_step
  import tsc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  tsc_req_if.sink        req_i,
  tsc_rsp_if.source      rsp_o
);

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_MEM  = 6'b000100,
    S_DEC  = 6'b001000,
    S_OPS  = 6'b010000,
    S_EXE  = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [15:0]      pc_q, pc_d;
  logic             halted_q, halted_d;
  logic [1:0]       func_q, func_d;
  logic [15:0]      iw_q, iw_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      diff_q, diff_d;
  logic [15:0]      r2_q, r2_d;
  tsc_res_t         res_q, res_d;
  logic             ovld_q, ovld_d;

  logic             pm_we, pm_re_a, pm_re_b;
  logic [AW-1:0]    pm_waddr, pm_raddr_a, pm_raddr_b;
  logic [15:0]      pm_wdata, pm_rdata_a, pm_rdata_b;
  logic             rf_we, rf_re_a, rf_re_b;
  logic [RF_AW-1:0] rf_waddr, rf_raddr_a, rf_raddr_b;
  logic [15:0]      rf_wdata, rf_rdata_a, rf_rdata_b;

  logic             slot_free;
  logic [15:0]      r1v, r2v, r3v;
  logic [15:0]      imm16, mag, offs;
  logic             wr_en;
  logic [15:0]      wr_val, pc_new;
  logic [3:0]       op;
  logic [RF_AW-1:0] r1;

  function automatic logic [15:0] opnd(input logic [RF_AW-1:0] idx,
                                       input logic [15:0] ram,
                                       input logic [15:0] pc);
    if (idx == REG_ZERO) begin
      return 16'd0;
    end else if (idx == REG_PC) begin
      return pc;
    end
    return ram;
  endfunction

  tsc_ram #(.WIDTH(16), .DEPTH(MEM_WORDS), .AW(AW)) u_pmem (
    .clk_i     (clk_i),
    .we_i      (pm_we),
    .waddr_i   (pm_waddr),
    .wdata_i   (pm_wdata),
    .re_a_i    (pm_re_a),
    .raddr_a_i (pm_raddr_a),
    .rdata_a_o (pm_rdata_a),
    .re_b_i    (pm_re_b),
    .raddr_b_i (pm_raddr_b),
    .rdata_b_o (pm_rdata_b)
  );

  tsc_ram #(.WIDTH(16), .DEPTH(RF_DEPTH), .AW(RF_AW)) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .re_a_i    (rf_re_a),
    .raddr_a_i (rf_raddr_a),
    .rdata_a_o (rf_rdata_a),
    .re_b_i    (rf_re_b),
    .raddr_b_i (rf_raddr_b),
    .rdata_b_o (rf_rdata_b)
  );

  assign slot_free = !ovld_q || rsp_o.ready;
  assign op        = iw_q[15:12];
  assign r1        = iw_q[11:8];

  // Register 15 reads the already advanced program counter.
  assign r2v = opnd(iw_q[7:4], rf_rdata_a, pc_q);
  assign r3v = opnd(iw_q[3:0], rf_rdata_b, pc_q);
  assign r1v = opnd(r1, rf_rdata_a, pc_q);

  // Sign-magnitude offset, minus one.
  assign imm16 = {8'h00, iw_q[7:0]};
  assign mag   = iw_q[7] ? (16'd128 - imm16) : imm16;
  assign offs  = mag - 16'd1;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pc_d       = pc_q;
    halted_d   = halted_q;
    func_d     = func_q;
    iw_d       = iw_q;
    sum_d      = sum_q;
    diff_d     = diff_q;
    r2_d       = r2_q;
    res_d      = res_q;
    ovld_d     = ovld_q && !rsp_o.ready;
    req_i.ready = 1'b0;
    pm_we      = 1'b0;
    pm_waddr   = '0;
    pm_wdata   = '0;
    pm_re_a    = 1'b0;
    pm_raddr_a = '0;
    pm_re_b    = 1'b0;
    pm_raddr_b = '0;
    rf_we      = 1'b0;
    rf_waddr   = '0;
    rf_wdata   = '0;
    rf_re_a    = 1'b0;
    rf_raddr_a = '0;
    rf_re_b    = 1'b0;
    rf_raddr_b = '0;
    wr_en      = 1'b0;
    wr_val     = '0;
    pc_new     = pc_q;

    unique case (state_q)
      S_CLR: begin
        pm_we    = 1'b1;
        pm_waddr = cnt_q;
        rf_we    = 1'b1;
        rf_waddr = cnt_q[RF_AW-1:0];
        cnt_d    = cnt_q + AW'(1);
        if (cnt_q == AW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          func_d  = req_i.func;
          state_d = S_MEM;
          case (req_i.func)
            FN_WRITE: begin
              pm_we    = 1'b1;
              pm_waddr = wrap_addr6(req_i.mem_address);
              pm_wdata = req_i.mem_data;
            end
            FN_EXEC: begin
              if (!halted_q) begin
                pm_re_a    = 1'b1;
                pm_raddr_a = pc_q[AW-1:0];
                state_d    = S_DEC;
              end
            end
            FN_READ: begin
              pm_re_a    = 1'b1;
              pm_raddr_a = wrap_addr6(req_i.mem_address);
            end
            default: ;
          endcase
        end
      end
      S_MEM: begin
        if (slot_free) begin
          ovld_d                = 1'b1;
          res_d.status          = (func_q == FN_EXEC) ? ST_HALT : ST_MEM;
          res_d.out_valid       = 1'b0;
          res_d.out_value       = '0;
          res_d.read_data       = (func_q == FN_READ) ? pm_rdata_a : 16'd0;
          res_d.program_counter = pc_q;
          state_d               = S_IDLE;
        end
      end
      S_DEC: begin
        iw_d       = pm_rdata_a;
        pc_d       = pc_q + 16'd1;
        rf_re_a    = 1'b1;
        rf_raddr_a = pm_rdata_a[7:4];
        rf_re_b    = 1'b1;
        rf_raddr_b = pm_rdata_a[3:0];
        state_d    = S_OPS;
      end
      S_OPS: begin
        sum_d      = r2v + r3v;
        diff_d     = r2v - r3v;
        r2_d       = r2v;
        rf_re_a    = 1'b1;
        rf_raddr_a = r1;
        // Port B fetches the load operand or the jump target word.
        pm_re_b    = 1'b1;
        pm_raddr_b = (op == OP_LOAD) ? sum_d[AW-1:0] : pc_q[AW-1:0];
        state_d    = S_EXE;
      end
      S_EXE: begin
        if (slot_free) begin
          res_d.status    = ST_EXEC;
          res_d.out_valid = 1'b0;
          res_d.out_value = '0;
          res_d.read_data = '0;
          unique case (op)
            OP_HALT: begin
              halted_d     = 1'b1;
              res_d.status = ST_HALT;
            end
            OP_ADD: begin
              wr_en  = 1'b1;
              wr_val = sum_q;
            end
            OP_SUB: begin
              wr_en  = 1'b1;
              wr_val = diff_q;
            end
            OP_LOAD: begin
              wr_en  = 1'b1;
              wr_val = pm_rdata_b;
            end
            OP_STORE: begin
              pm_we    = 1'b1;
              pm_waddr = sum_q[AW-1:0];
              pm_wdata = r1v;
            end
            OP_LDL: begin
              wr_en  = 1'b1;
              wr_val = {r1v[15:8], iw_q[7:0]};
            end
            OP_LDH: begin
              wr_en  = 1'b1;
              wr_val = {iw_q[7:0], r1v[7:0]};
            end
            OP_MOVE: begin
              wr_en  = 1'b1;
              wr_val = r2_q;
            end
            OP_JUMP: begin
              pc_new = pm_rdata_b;
            end
            OP_BR: begin
              pc_new = pc_q + r1v + offs;
            end
            OP_BZ: begin
              if (r1v == 16'd0) begin
                pc_new = pc_q + offs;
              end
            end
            OP_OUT: begin
              res_d.out_valid = 1'b1;
              res_d.out_value = r1v;
            end
            default: ;
          endcase
          if (wr_en) begin
            if (r1 == REG_PC) begin
              pc_new = wr_val;
            end else if (r1 != REG_ZERO) begin
              rf_we    = 1'b1;
              rf_waddr = r1;
              rf_wdata = wr_val;
            end
          end
          pc_d                  = pc_new;
          res_d.program_counter = pc_new;
          ovld_d                = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      cnt_q    <= '0;
      pc_q     <= '0;
      halted_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    iw_q   <= iw_d;
    sum_q  <= sum_d;
    diff_q <= diff_d;
    r2_q   <= r2_d;
    res_q  <= res_d;
  end

  assign rsp_o.valid           = ovld_q;
  assign rsp_o.status          = res_q.status;
  assign rsp_o.out_valid       = res_q.out_valid;
  assign rsp_o.out_value       = res_q.out_value;
  assign rsp_o.read_data       = res_q.read_data;
  assign rsp_o.program_counter = res_q.program_counter;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the tiny 16-bit processor step block.
module tb_top
  import tsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_NONE = 2'd3;  // unused function code
  localparam int N_RANDOM = 800;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam tsc_res_t MEM_AFTER_RESET = '{status: ST_MEM, out_valid: 1'b0,
                                          out_value: 16'h0, read_data: 16'h0,
                                          program_counter: 16'h0};

  typedef struct packed {
    bit          late;   // run after the random part (halt and beyond)
    logic [1:0]  func;
    logic [5:0]  addr;
    bit          at_pc;  // address taken from the current program counter
    logic [15:0] data;
    bit          known;  // expectation typed in, not predicted
  } dir_row_t;

  logic clk;
  logic rst_n;

  tsc_req_if req_if ();
  tsc_rsp_if rsp_if ();

  tiny_sixteen_bit_cpu_step dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predictor state
  logic [15:0] gpr [RF_DEPTH];
  logic [15:0] imem [MEM_WORDS];
  bit          cpu_halted;

  tsc_res_t pending_rsp [$];
  dir_row_t dir_tab [$];

  int send_pct;
  int stall_pct;
  int mismatches;
  int idle_cycles;
  int n_exec, n_halt, n_out, n_mem;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] gpr_rd(input logic [3:0] r);
    return (r == REG_ZERO) ? 16'h0 : gpr[r];
  endfunction

  function automatic void gpr_wr(input logic [3:0] r, input logic [15:0] v);
    if (r != REG_ZERO) gpr[r] = v;
  endfunction

  function automatic logic [5:0] pc_slot();
    return 6'(gpr[REG_PC] % MEM_WORDS);
  endfunction

  function automatic tsc_res_t cpu_step_predict(input logic [1:0] f, input logic [5:0] a,
                                                input logic [15:0] d);
    tsc_res_t    res;
    logic [15:0] pc, iw, ofs, ea;
    logic [7:0]  imm;
    logic [3:0]  op, r1, r2, r3;
    res = '0;
    res.status = ST_MEM;
    case (f)
      FN_WRITE: imem[a % MEM_WORDS] = d;
      FN_READ:  res.read_data = imem[a % MEM_WORDS];
      FN_EXEC: begin
        if (cpu_halted) begin
          res.status = ST_HALT;
        end else begin
          pc = gpr[REG_PC];
          iw = imem[pc % MEM_WORDS];
          gpr[REG_PC] = pc + 16'd1;
          {op, r1, r2, r3} = iw;
          imm = iw[7:0];
          // sign bit over a 7-bit magnitude, then minus one
          ofs = (imm > 8'd127) ? (16'd128 - {8'h0, imm}) : {8'h0, imm};
          ofs = ofs - 16'd1;
          res.status = ST_EXEC;
          case (op)
            OP_HALT: begin
              cpu_halted = 1'b1;
              res.status = ST_HALT;
            end
            OP_ADD:  gpr_wr(r1, gpr_rd(r2) + gpr_rd(r3));
            OP_SUB:  gpr_wr(r1, gpr_rd(r2) - gpr_rd(r3));
            OP_LOAD: begin
              ea = gpr_rd(r2) + gpr_rd(r3);
              gpr_wr(r1, imem[ea % MEM_WORDS]);
            end
            OP_STORE: begin
              ea = gpr_rd(r2) + gpr_rd(r3);
              imem[ea % MEM_WORDS] = gpr_rd(r1);
            end
            OP_LDL:  gpr_wr(r1, (gpr_rd(r1) & 16'hFF00) | {8'h00, imm});
            OP_LDH:  gpr_wr(r1, (gpr_rd(r1) & 16'h00FF) | {imm, 8'h00});
            OP_MOVE: gpr_wr(r1, gpr_rd(r2));
            OP_JUMP: gpr[REG_PC] = imem[gpr[REG_PC] % MEM_WORDS];
            OP_BR:   gpr[REG_PC] = gpr[REG_PC] + gpr_rd(r1) + ofs;
            OP_BZ: begin
              if (gpr_rd(r1) == 16'h0) gpr[REG_PC] = gpr[REG_PC] + ofs;
            end
            OP_OUT: begin
              res.out_valid = 1'b1;
              res.out_value = gpr_rd(r1);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    res.program_counter = gpr[REG_PC];
    return res;
  endfunction

  // Any instruction word except halt
  function automatic logic [15:0] rand_instr();
    return {4'($urandom_range(15, 1)), 12'($urandom)};
  endfunction

  task automatic add_row(input bit late, input logic [1:0] f, input logic [5:0] a,
                         input bit at_pc, input logic [15:0] d, input bit known);
    dir_tab.push_back('{late, f, a, at_pc, d, known});
  endtask

  task automatic issue(input logic [1:0] f, input logic [5:0] a, input logic [15:0] d,
                       input bit known);
    tsc_res_t want;
    want = cpu_step_predict(f, a, d);
    if (known) want = MEM_AFTER_RESET;
    pending_rsp.push_back(want);
    if ($urandom_range(99) < send_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= f;
    req_if.mem_address <= a;
    req_if.mem_data    <= d;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic walk_table(input bit late);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].late == late)
        issue(dir_tab[i].func, dir_tab[i].at_pc ? pc_slot() : dir_tab[i].addr,
              dir_tab[i].data, dir_tab[i].known);
    end
  endtask

  // Response checker and receiver stalls
  always @(posedge clk) begin : rsp_mon
    tsc_res_t got, want;
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.status, rsp_if.out_valid, rsp_if.out_value, rsp_if.read_data,
             rsp_if.program_counter};
      case (got.status)
        ST_EXEC: n_exec++;
        ST_HALT: n_halt++;
        default: n_mem++;
      endcase
      if (got.out_valid) n_out++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response st=%0d ov=%0b oval=%h rd=%h pc=%h",
                   got.status, got.out_valid, got.out_value, got.read_data,
                   got.program_counter);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.out_valid !== want.out_valid ||
            got.out_value !== want.out_value || got.read_data !== want.read_data ||
            got.program_counter !== want.program_counter) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want st=%0d ov=%0b oval=%h rd=%h pc=%h",
                     want.status, want.out_valid, want.out_value, want.read_data,
                     want.program_counter);
            $display("          got  st=%0d ov=%0b oval=%h rd=%h pc=%h",
                     got.status, got.out_valid, got.out_value, got.read_data,
                     got.program_counter);
          end
        end
      end
    end
  end

  // Watchdog: cycles without any accepted request or response
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_CYCLES);
        $display("** tiny_sixteen_bit_cpu_step: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stim
    int n_items;
    int k;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.func        = FN_WRITE;
    req_if.mem_address = '0;
    req_if.mem_data    = '0;
    rsp_if.ready       = 1'b0;
    send_pct    = 0;
    stall_pct   = 0;
    mismatches  = 0;
    idle_cycles = 0;
    n_exec = 0;
    n_halt = 0;
    n_out  = 0;
    n_mem  = 0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (imem[i]) imem[i] = '0;
    cpu_halted = 1'b0;

    // memory items right after reset, then a short program
    add_row(1'b0, FN_READ,  6'd63, 1'b0, 16'h0000, 1'b1);
    add_row(1'b0, FN_READ,  6'd0,  1'b0, 16'h0000, 1'b1);
    add_row(1'b0, FN_NONE,  6'd63, 1'b0, 16'hFFFF, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd0,  1'b0, {OP_LDH, 4'd1, 8'hFF}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd1,  1'b0, {OP_LDL, 4'd1, 8'hFF}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd2,  1'b0, {OP_ADD, 4'd2, 4'd1, 4'd1}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd3,  1'b0, {OP_SUB, 4'd3, REG_ZERO, 4'd1}, 1'b1);
    // store lands at 0xFFFF, wraps to the last word
    add_row(1'b0, FN_WRITE, 6'd4,  1'b0, {OP_STORE, 4'd1, 4'd2, 4'd3}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd5,  1'b0, {OP_LOAD, 4'd4, 4'd3, REG_ZERO}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd6,  1'b0, {OP_MOVE, REG_ZERO, 4'd1, 4'd0}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd7,  1'b0, {OP_OUT, 4'd4, 8'h00}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd8,  1'b0, {OP_OUT, REG_PC, 8'h00}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd9,  1'b0, {OP_BZ, REG_ZERO, 8'h03}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd12, 1'b0, {OP_BR, REG_ZERO, 8'h81}, 1'b1);
    add_row(1'b0, FN_WRITE, 6'd11, 1'b0, {OP_JUMP, 12'h000}, 1'b1);
    repeat (12) add_row(1'b0, FN_EXEC, 6'd0, 1'b0, 16'h0000, 1'b0);
    // halt, then everything that still works afterwards
    add_row(1'b1, FN_WRITE, 6'd0,  1'b1, {OP_HALT, 12'h000}, 1'b0);
    add_row(1'b1, FN_EXEC,  6'd0,  1'b0, 16'h0000, 1'b0);
    add_row(1'b1, FN_EXEC,  6'd0,  1'b0, 16'h0000, 1'b0);
    add_row(1'b1, FN_WRITE, 6'd0,  1'b0, 16'hFFFF, 1'b0);
    add_row(1'b1, FN_READ,  6'd0,  1'b1, 16'h0000, 1'b0);
    add_row(1'b1, FN_NONE,  6'd0,  1'b1, 16'hFFFF, 1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    walk_table(1'b0);

    n_items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 70; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 70; end
        default: begin send_pct = 32; stall_pct = 32; end
      endcase
      while (n_items < (ph + 1) * N_RANDOM / 4) begin
        k = $urandom_range(99);
        if (k < 55) begin
          // keep the program running: never fetch a halt word here
          if (imem[gpr[REG_PC] % MEM_WORDS][15:12] == OP_HALT) begin
            issue(FN_WRITE, pc_slot(), rand_instr(), 1'b0);
            n_items++;
          end
          issue(FN_EXEC, 6'($urandom), 16'($urandom), 1'b0);
          n_items++;
        end else if (k < 75) begin
          issue(FN_WRITE, 6'($urandom), $urandom_range(1) ? rand_instr() : 16'($urandom),
                1'b0);
          n_items++;
        end else if (k < 92) begin
          issue(FN_READ, 6'($urandom), 16'($urandom), 1'b0);
          n_items++;
        end else begin
          issue(FN_NONE, 6'($urandom), 16'($urandom), 1'b0);
          n_items++;
        end
      end
    end

    walk_table(1'b1);
    req_if.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d executed instructions (%0d with output), %0d halted steps,",
             n_exec, n_out, n_halt);
    $display("%0d memory requests, over four sender/receiver stall profiles; %0d mismatches",
             n_mem, mismatches);
    if (mismatches == 0) begin
      $display("** tiny_sixteen_bit_cpu_step: PASSED **");
    end else begin
      $display("** tiny_sixteen_bit_cpu_step: FAILED **");
    end
    $finish;
  end

endmodule
